// ----- src/twcc_status_chunk_decoder_macros.svh -----
// Assertion helpers for the status chunk decoder.
// Each expects clk and rst_n in scope.
`ifndef TWCC_STATUS_CHUNK_DECODER_MACROS_SVH
`define TWCC_STATUS_CHUNK_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tcd_pkg.sv -----
package tcd_pkg;

    // input opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_CHUNK = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // result kinds
    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // summary error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_DATA  = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    // chunk layout
    localparam int VECTOR_BIT   = 15;
    localparam int WIDE_SYM_BIT = 14;

    localparam logic [3:0] VEC_SYMS_NARROW = 4'd14;
    localparam logic [3:0] VEC_SYMS_WIDE   = 4'd7;

    localparam logic [16:0] CHUNK_BYTES_MAX = 17'd131070;
    localparam logic [15:0] CAPACITY_RESET  = 16'hFFFF;

    typedef struct packed {
        logic        load;
        logic        shift;
        logic        wide;
    } shift_ctl_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] first_seq;
        logic [12:0] length;
        logic [1:0]  status;
        logic [15:0] recv_total;
        logic [16:0] st_bytes;
        logic [17:0] tm_bytes;
        logic [1:0]  err;
    } row_t;

endpackage

// ----- src/tcd_digit_shift.sv -----
// Status vector shifter: presents one symbol per cycle while shift is asserted, most significant first.
module tcd_digit_shift
(
    input  logic                clk,
    input  logic                rst_n,
    input  tcd_pkg::shift_ctl_t ctl,
    input  logic [13:0]         word,
    output logic [1:0]          sym,
    output logic                empty
);

    logic [13:0] sr_reg;
    logic [13:0] sr_next;
    logic [3:0]  left_reg;
    logic [3:0]  left_next;
    logic        wide_reg;
    logic        wide_next;

    always_comb
    begin
        sr_next   = sr_reg;
        left_next = left_reg;
        wide_next = wide_reg;
        if (ctl.load)
        begin
            sr_next   = word;
            wide_next = ctl.wide;
            left_next = ctl.wide ? tcd_pkg::VEC_SYMS_WIDE : tcd_pkg::VEC_SYMS_NARROW;
        end
        else if (ctl.shift)
        begin
            sr_next   = wide_reg ? {sr_reg[11:0], 2'b00} : {sr_reg[12:0], 1'b0};
            left_next = left_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            wide_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            wide_reg <= wide_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    assign sym   = wide_reg ? sr_reg[13:12] : {1'b0, sr_reg[13]};
    assign empty = (left_reg == 4'd0);

endmodule

// ----- src/tcd_out_reg.sv -----
`include "twcc_status_chunk_decoder_macros.svh"

// Result output register.
module tcd_out_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  tcd_pkg::row_t row,
    input  logic          row_last,
    output logic          ready,
    input  logic          out_stall,
    output logic          out_valid,
    output logic          result_kind,
    output logic [15:0]   run_first_sequence,
    output logic [12:0]   run_length,
    output logic [1:0]    run_status,
    output logic [15:0]   received_total,
    output logic [16:0]   status_bytes,
    output logic [17:0]   timing_bytes,
    output logic [1:0]    error_code,
    output logic          last
);

    logic          valid_reg;
    logic          valid_next;
    tcd_pkg::row_t row_reg;
    logic          last_reg;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= row;
            last_reg <= row_last;
        end
    end

    assign out_valid          = valid_reg;
    assign result_kind        = row_reg.kind;
    assign run_first_sequence = row_reg.first_seq;
    assign run_length         = row_reg.length;
    assign run_status         = row_reg.status;
    assign received_total     = row_reg.recv_total;
    assign status_bytes       = row_reg.st_bytes;
    assign timing_bytes       = row_reg.tm_bytes;
    assign error_code         = row_reg.err;
    assign last               = last_reg;

    // a load into a held, stalled result would drop a result
    `TCD_ASSERT_SAME(a_load_when_ready, load, ready, "output load while stalled")
    `TCD_ASSERT_NEXT(a_load_shows, load, valid_reg, "loaded result not shown")

endmodule

// ----- src/twcc_status_chunk_decoder.sv -----
// Transport-wide congestion feedback status chunk decoder. Send a begin
// transaction (opcode 0) with the base sequence number and status count,
// then one transaction per 16-bit status chunk (opcode 1), and an end
// transaction (opcode 2) when the payload runs out. Packets with a nonzero
// status come out as runs (first sequence, length, status), then a summary
// closes the message with totals and an error code: 1 if the end arrived
// before the status count was met, 2 if more packets were received than
// receive_capacity allows. The last flag marks the final result of an
// input transaction. One transaction is worked on at a time. A status
// vector chunk is shifted out one symbol per cycle while the output
// register has room, up to 7 two-bit or 14 one-bit symbols; a run-length
// chunk is resolved arithmetically whatever its run length, in clamp,
// capacity, multiply and apply steps, the last two skipped for status
// zero. A chunk with no message open or an unused opcode is dropped in
// the idle state. Each result needs a free output register. A finished
// result may wait in the output register while the next transaction is
// taken. Write receive_capacity only while the block is idle.
`include "twcc_status_chunk_decoder_macros.svh"

module twcc_status_chunk_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] base_sequence,
    input  logic [15:0] status_count,
    input  logic [15:0] chunk_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] run_first_sequence,
    output logic [12:0] run_length,
    output logic [1:0]  run_status,
    output logic [15:0] received_total,
    output logic [16:0] status_bytes,
    output logic [17:0] timing_bytes,
    output logic [1:0]  error_code,
    output logic        last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_VEC      = 4'd1;
    localparam logic [3:0] S_RL_CLAMP = 4'd2;
    localparam logic [3:0] S_RL_CAP   = 4'd3;
    localparam logic [3:0] S_RL_MUL   = 4'd4;
    localparam logic [3:0] S_RL_APPLY = 4'd5;
    localparam logic [3:0] S_FLUSH    = 4'd6;
    localparam logic [3:0] S_SUMMARY  = 4'd7;
    localparam logic [3:0] S_END      = 4'd8;

    logic [3:0]  state_reg, state_next;

    logic [15:0] cap_reg;

    // message state
    logic [15:0] base_reg, base_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] index_reg, index_next;
    logic [15:0] recv_reg, recv_next;
    logic [16:0] cbytes_reg, cbytes_next;
    logic [17:0] timing_reg, timing_next;
    logic        done_reg, done_next;
    logic        fail_reg, fail_next;

    // open run inside a status vector
    logic        run_open_reg, run_open_next;
    logic [15:0] run_seq_reg, run_seq_next;
    logic [12:0] run_len_reg, run_len_next;
    logic [1:0]  run_sym_reg, run_sym_next;

    // run-length chunk arithmetic
    logic [12:0] rl_len_reg, rl_len_next;
    logic [1:0]  rl_sym_reg, rl_sym_next;
    logic [12:0] rl_n_reg, rl_n_next;
    logic [12:0] rl_k_reg, rl_k_next;
    logic        rl_short_reg, rl_short_next;
    logic [15:0] rl_prod_reg, rl_prod_next;

    // one result held back until we know whether it is the last one
    tcd_pkg::row_t pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;

    tcd_pkg::shift_ctl_t sh_ctl;
    logic [1:0]          sh_sym;
    logic                sh_empty;

    logic          out_ready;
    logic          out_load;
    logic          out_last;
    logic          in_accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    function automatic tcd_pkg::row_t make_row(
        input logic        kind,
        input logic [15:0] seq,
        input logic [12:0] len,
        input logic [1:0]  sym,
        input logic [15:0] recv,
        input logic [16:0] sb,
        input logic [17:0] tb,
        input logic [1:0]  err
    );
        tcd_pkg::row_t r;
        r.kind       = kind;
        r.first_seq  = seq;
        r.length     = len;
        r.status     = sym;
        r.recv_total = recv;
        r.st_bytes   = sb;
        r.tm_bytes   = tb;
        r.err        = err;
        return r;
    endfunction

    tcd_digit_shift u_shift
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sh_ctl),
        .word  (chunk_word[13:0]),
        .sym   (sh_sym),
        .empty (sh_empty)
    );

    always_comb
    begin
        logic          emit;
        tcd_pkg::row_t emit_row;
        logic [17:0]   tsum;
        logic [15:0]   rnew;
        logic [15:0]   remain;
        logic [15:0]   avail;
        logic          shortfall;
        logic [13:0]   kk;
        logic [15:0]   prod1;
        logic [15:0]   prod2;

        state_next      = state_reg;
        base_next       = base_reg;
        total_next      = total_reg;
        index_next      = index_reg;
        recv_next       = recv_reg;
        cbytes_next     = cbytes_reg;
        timing_next     = timing_reg;
        done_next       = done_reg;
        fail_next       = fail_reg;
        run_open_next   = run_open_reg;
        run_seq_next    = run_seq_reg;
        run_len_next    = run_len_reg;
        run_sym_next    = run_sym_reg;
        rl_len_next     = rl_len_reg;
        rl_sym_next     = rl_sym_reg;
        rl_n_next       = rl_n_reg;
        rl_k_next       = rl_k_reg;
        rl_short_next   = rl_short_reg;
        rl_prod_next    = rl_prod_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        sh_ctl          = '0;
        out_load        = 1'b0;
        out_last        = 1'b0;
        emit            = 1'b0;
        emit_row        = '0;
        tsum            = '0;
        rnew            = '0;
        remain          = '0;
        avail           = '0;
        shortfall       = 1'b0;
        kk              = '0;
        prod1           = '0;
        prod2           = '0;

        // every busy step may push the held result out, so it waits for room
        if (state_reg == S_IDLE || out_ready)
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (opcode)
                            tcd_pkg::OP_BEGIN:
                            begin
                                base_next   = base_sequence;
                                total_next  = status_count;
                                index_next  = '0;
                                recv_next   = '0;
                                cbytes_next = '0;
                                timing_next = '0;
                                done_next   = 1'b0;
                                if (status_count == 16'd0)
                                begin
                                    // empty message completes at once
                                    emit      = 1'b1;
                                    emit_row  = make_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0,
                                                         '0, '0, '0, tcd_pkg::ERR_NONE);
                                    done_next = 1'b1;
                                end
                                state_next = S_END;
                            end
                            tcd_pkg::OP_END:
                            begin
                                if (!done_reg)
                                begin
                                    emit      = 1'b1;
                                    emit_row  = make_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0,
                                                         recv_reg, cbytes_reg, timing_reg,
                                                         tcd_pkg::ERR_NO_DATA);
                                    done_next = 1'b1;
                                end
                                state_next = S_END;
                            end
                            tcd_pkg::OP_CHUNK:
                            begin
                                if (!done_reg)
                                begin
                                    if (cbytes_reg >= tcd_pkg::CHUNK_BYTES_MAX - 17'd2)
                                        cbytes_next = tcd_pkg::CHUNK_BYTES_MAX;
                                    else
                                        cbytes_next = cbytes_reg + 17'd2;
                                    fail_next     = 1'b0;
                                    run_open_next = 1'b0;
                                    if (chunk_word[tcd_pkg::VECTOR_BIT])
                                    begin
                                        sh_ctl.load = 1'b1;
                                        sh_ctl.wide = chunk_word[tcd_pkg::WIDE_SYM_BIT];
                                        state_next  = S_VEC;
                                    end
                                    else
                                    begin
                                        rl_len_next = chunk_word[12:0];
                                        rl_sym_next = chunk_word[14:13];
                                        state_next  = S_RL_CLAMP;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // one status symbol per cycle while the output register has room
                S_VEC:
                begin
                    if (sh_empty || index_reg >= total_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        tsum        = timing_reg + 18'(sh_sym);
                        timing_next = tsum;
                        if (sh_sym == 2'd0)
                        begin
                            if (run_open_reg)
                            begin
                                emit     = 1'b1;
                                emit_row = make_row(tcd_pkg::KIND_RUN, run_seq_reg,
                                                    run_len_reg, run_sym_reg, recv_reg,
                                                    cbytes_reg, tsum, tcd_pkg::ERR_NONE);
                            end
                            run_open_next = 1'b0;
                            index_next    = index_reg + 16'd1;
                            sh_ctl.shift  = 1'b1;
                        end
                        else if (recv_reg >= cap_reg)
                        begin
                            // symbol still counts toward timing bytes
                            fail_next  = 1'b1;
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            rnew      = recv_reg + 16'd1;
                            recv_next = rnew;
                            if (run_open_reg && run_sym_reg == sh_sym)
                            begin
                                run_len_next = run_len_reg + 13'd1;
                            end
                            else
                            begin
                                if (run_open_reg)
                                begin
                                    emit     = 1'b1;
                                    emit_row = make_row(tcd_pkg::KIND_RUN, run_seq_reg,
                                                        run_len_reg, run_sym_reg, rnew,
                                                        cbytes_reg, tsum, tcd_pkg::ERR_NONE);
                                end
                                run_open_next = 1'b1;
                                run_seq_next  = base_reg + index_reg;
                                run_len_next  = 13'd1;
                                run_sym_next  = sh_sym;
                            end
                            index_next   = index_reg + 16'd1;
                            sh_ctl.shift = 1'b1;
                        end
                    end
                end

                // statuses the chunk may still supply
                S_RL_CLAMP:
                begin
                    remain = total_reg - index_reg;
                    if ({3'b000, rl_len_reg} < remain)
                        rl_n_next = rl_len_reg;
                    else
                        rl_n_next = remain[12:0];
                    state_next = S_RL_CAP;
                end

                // packets that fit under the capacity
                S_RL_CAP:
                begin
                    if (rl_sym_reg == 2'd0)
                    begin
                        index_next = index_reg + 16'(rl_n_reg);
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        avail     = (recv_reg >= cap_reg) ? 16'd0 : cap_reg - recv_reg;
                        shortfall = (avail < {3'b000, rl_n_reg});
                        rl_k_next     = shortfall ? avail[12:0] : rl_n_reg;
                        rl_short_next = shortfall;
                        state_next    = S_RL_MUL;
                    end
                end

                // timing contribution: symbol times taken count, plus the
                // rejected status on a capacity hit
                S_RL_MUL:
                begin
                    kk    = 14'(rl_k_reg) + 14'(rl_short_reg);
                    prod1 = rl_sym_reg[0] ? {2'b00, kk} : 16'd0;
                    prod2 = rl_sym_reg[1] ? {1'b0, kk, 1'b0} : 16'd0;
                    rl_prod_next = prod1 + prod2;
                    state_next   = S_RL_APPLY;
                end

                S_RL_APPLY:
                begin
                    tsum        = timing_reg + 18'(rl_prod_reg);
                    rnew        = recv_reg + 16'(rl_k_reg);
                    timing_next = tsum;
                    recv_next   = rnew;
                    index_next  = index_reg + 16'(rl_k_reg);
                    fail_next   = rl_short_reg;
                    if (rl_k_reg != 13'd0)
                    begin
                        emit     = 1'b1;
                        emit_row = make_row(tcd_pkg::KIND_RUN, base_reg + index_reg,
                                            rl_k_reg, rl_sym_reg, rnew, cbytes_reg, tsum,
                                            tcd_pkg::ERR_NONE);
                    end
                    state_next = S_FLUSH;
                end

                S_FLUSH:
                begin
                    if (run_open_reg)
                    begin
                        emit     = 1'b1;
                        emit_row = make_row(tcd_pkg::KIND_RUN, run_seq_reg, run_len_reg,
                                            run_sym_reg, recv_reg, cbytes_reg, timing_reg,
                                            tcd_pkg::ERR_NONE);
                    end
                    run_open_next = 1'b0;
                    state_next    = S_SUMMARY;
                end

                S_SUMMARY:
                begin
                    if (fail_reg)
                    begin
                        emit      = 1'b1;
                        emit_row  = make_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, recv_reg,
                                             cbytes_reg, timing_reg, tcd_pkg::ERR_CAPACITY);
                        done_next = 1'b1;
                    end
                    else if (index_reg >= total_reg)
                    begin
                        emit      = 1'b1;
                        emit_row  = make_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, recv_reg,
                                             cbytes_reg, timing_reg, tcd_pkg::ERR_NONE);
                        done_next = 1'b1;
                    end
                    state_next = S_END;
                end

                // held result is the final one of this transaction
                S_END:
                begin
                    if (pend_valid_reg)
                    begin
                        out_load        = 1'b1;
                        out_last        = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end

                default:
                begin
                    state_next = S_IDLE;
                end
            endcase

            // a new result pushes the held one out, not last
            if (emit)
            begin
                if (pend_valid_reg)
                    out_load = 1'b1;
                pend_next       = emit_row;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= tcd_pkg::CAPACITY_RESET;
            base_reg       <= '0;
            total_reg      <= '0;
            index_reg      <= '0;
            recv_reg       <= '0;
            cbytes_reg     <= '0;
            timing_reg     <= '0;
            done_reg       <= 1'b1;
            fail_reg       <= 1'b0;
            run_open_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            base_reg       <= base_next;
            total_reg      <= total_next;
            index_reg      <= index_next;
            recv_reg       <= recv_next;
            cbytes_reg     <= cbytes_next;
            timing_reg     <= timing_next;
            done_reg       <= done_next;
            fail_reg       <= fail_next;
            run_open_reg   <= run_open_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_seq_reg  <= run_seq_next;
        run_len_reg  <= run_len_next;
        run_sym_reg  <= run_sym_next;
        rl_len_reg   <= rl_len_next;
        rl_sym_reg   <= rl_sym_next;
        rl_n_reg     <= rl_n_next;
        rl_k_reg     <= rl_k_next;
        rl_short_reg <= rl_short_next;
        rl_prod_reg  <= rl_prod_next;
        pend_reg     <= pend_next;
    end

    tcd_out_reg u_out
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (out_load),
        .row                (pend_reg),
        .row_last           (out_last),
        .ready              (out_ready),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .result_kind        (result_kind),
        .run_first_sequence (run_first_sequence),
        .run_length         (run_length),
        .run_status         (run_status),
        .received_total     (received_total),
        .status_bytes       (status_bytes),
        .timing_bytes       (timing_bytes),
        .error_code         (error_code),
        .last               (last)
    );

    // nothing may be held back once a transaction is finished
    `TCD_ASSERT_SAME(a_idle_no_pend, state_reg == S_IDLE, !pend_valid_reg,
        "result held while idle")
    // an open message never has consumed more statuses than it announced
    `TCD_ASSERT_SAME(a_index_bound, !done_reg, index_reg <= total_reg,
        "status index past count")
    // chunks move two bytes at a time, saturation value is even too
    `TCD_ASSERT_SAME(a_bytes_even, 1'b1, cbytes_reg[0] == 1'b0, "odd status byte count")
    `TCD_ASSERT_NEXT(a_end_returns, state_reg == S_END && out_ready, state_reg == S_IDLE,
        "end step did not return to idle")

endmodule

// ----- verif/tb_twcc_status_chunk_decoder.sv -----
// Testbench for twcc_status_chunk_decoder.
//
// The driver pulls transactions from pending_txns and offers them on the input
// valid/stall channel. Each accepted transaction goes straight into the
// status decode predictor, which appends the runs and the summary it expects
// to expected_results. The monitor pops one expectation per accepted result
// and compares every field.
//
// The run is split into segments. Each segment may change the idle mix and
// the receive capacity, fills the pending queue, then drains fully before the
// next capacity write.

module tb_twcc_status_chunk_decoder;

    // opcode 3 is not decoded; the block drops it
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    // settle time after the last result: covers one full one-bit status
    // vector plus the output register, with margin
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    // one long receiver hold-off, started after this many input transactions
    localparam int HOLD_AFTER    = 50;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] base_sequence;
        logic [15:0] status_count;
        logic [15:0] chunk_word;
    } decoder_txn_t;

    typedef struct packed {
        tcd_pkg::row_t row;
        logic          last;
    } expected_result_t;

    // ---------------------------------------------------------------------
    // DUT signals; everything the testbench drives starts at a known value
    // ---------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = tcd_pkg::OP_BEGIN;
    logic [15:0] base_sequence = '0;
    logic [15:0] status_count = '0;
    logic [15:0] chunk_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [15:0] run_first_sequence;
    logic [12:0] run_length;
    logic [1:0]  run_status;
    logic [15:0] received_total;
    logic [16:0] status_bytes;
    logic [17:0] timing_bytes;
    logic [1:0]  error_code;
    logic        last;

    twcc_status_chunk_decoder dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .opcode             (opcode),
        .base_sequence      (base_sequence),
        .status_count       (status_count),
        .chunk_word         (chunk_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .result_kind        (result_kind),
        .run_first_sequence (run_first_sequence),
        .run_length         (run_length),
        .run_status         (run_status),
        .received_total     (received_total),
        .status_bytes       (status_bytes),
        .timing_bytes       (timing_bytes),
        .error_code         (error_code),
        .last               (last)
    );

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    decoder_txn_t     pending_txns[$];
    expected_result_t expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accepted_txns = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // predictor copy of the block state
    logic [15:0] capacity_setting = tcd_pkg::CAPACITY_RESET;
    logic [15:0] msg_base = '0;
    logic [15:0] msg_total = '0;
    logic [15:0] status_idx = '0;
    logic [15:0] rx_count = '0;
    logic [16:0] chunk_byte_count = '0;
    logic [17:0] timing_total = '0;
    bit          msg_done = 1'b1;

    // run being gathered inside the current chunk
    bit          open_run;
    logic [15:0] run_seq;
    logic [12:0] run_len;
    logic [1:0]  run_sym;

    // newest result of the current transaction is held back so that the
    // final one can carry last
    bit            row_held;
    tcd_pkg::row_t held_row;

    // ---------------------------------------------------------------------
    // Clock and cycle limit
    // ---------------------------------------------------------------------
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Status decode predictor
    // ---------------------------------------------------------------------
    task automatic emit_row(input logic kind, input logic [15:0] seq,
                            input logic [12:0] len, input logic [1:0] sym,
                            input logic [1:0] err);
        expected_result_t entry;
        if (row_held)
        begin
            entry.row  = held_row;
            entry.last = 1'b0;
            expected_results.push_back(entry);
        end
        held_row.kind       = kind;
        held_row.first_seq  = seq;
        held_row.length     = len;
        held_row.status     = sym;
        held_row.recv_total = rx_count;
        held_row.st_bytes   = chunk_byte_count;
        held_row.tm_bytes   = timing_total;
        held_row.err        = err;
        row_held = 1'b1;
    endtask

    task automatic close_run();
        if (open_run)
        begin
            emit_row(tcd_pkg::KIND_RUN, run_seq, run_len, run_sym, tcd_pkg::ERR_NONE);
            open_run = 1'b0;
        end
    endtask

    // one packet status; ok drops when the capacity is already used up
    task automatic take_symbol(input logic [1:0] sym, output bit ok);
        ok = 1'b1;
        timing_total = timing_total + sym;
        if (sym == 2'd0)
            close_run();
        else if (rx_count >= capacity_setting)
            ok = 1'b0;
        else
        begin
            rx_count = rx_count + 1'b1;
            if (open_run && run_sym == sym)
                run_len = run_len + 1'b1;
            else
            begin
                close_run();
                open_run = 1'b1;
                run_seq  = msg_base + status_idx;
                run_len  = 13'd1;
                run_sym  = sym;
            end
        end
        if (ok)
            status_idx = status_idx + 1'b1;
    endtask

    task automatic predict_status_decode(input decoder_txn_t txn);
        bit          ok;
        int unsigned sym_w;
        int unsigned n_syms;
        int unsigned i;
        logic [15:0] shifted;
        logic [1:0]  sym;
        expected_result_t entry;
        open_run = 1'b0;
        row_held = 1'b0;
        ok = 1'b1;
        case (txn.opcode)
            tcd_pkg::OP_BEGIN:
            begin
                // a message still open is dropped silently
                msg_base         = txn.base_sequence;
                msg_total        = txn.status_count;
                status_idx       = '0;
                rx_count         = '0;
                chunk_byte_count = '0;
                timing_total     = '0;
                msg_done         = 1'b0;
                if (msg_total == 16'd0)
                begin
                    emit_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, tcd_pkg::ERR_NONE);
                    msg_done = 1'b1;
                end
            end
            tcd_pkg::OP_END:
            begin
                if (!msg_done)
                begin
                    emit_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, tcd_pkg::ERR_NO_DATA);
                    msg_done = 1'b1;
                end
            end
            tcd_pkg::OP_CHUNK:
            begin
                if (!msg_done)
                begin
                    // byte count saturates instead of wrapping
                    if (chunk_byte_count >= tcd_pkg::CHUNK_BYTES_MAX - 17'd2)
                        chunk_byte_count = tcd_pkg::CHUNK_BYTES_MAX;
                    else
                        chunk_byte_count = chunk_byte_count + 17'd2;
                    if (txn.chunk_word[tcd_pkg::VECTOR_BIT])
                    begin
                        // status vector, most significant symbol first
                        sym_w  = txn.chunk_word[tcd_pkg::WIDE_SYM_BIT] ? 2 : 1;
                        n_syms = 14 / sym_w;
                        for (i = 0; i < n_syms && ok && status_idx < msg_total; i++)
                        begin
                            shifted = txn.chunk_word >> (14 - sym_w * (i + 1));
                            sym = txn.chunk_word[tcd_pkg::WIDE_SYM_BIT]
                                ? shifted[1:0] : {1'b0, shifted[0]};
                            take_symbol(sym, ok);
                        end
                    end
                    else
                    begin
                        // run-length chunk
                        for (i = 0; i < txn.chunk_word[12:0] && ok && status_idx < msg_total;
                             i++)
                            take_symbol(txn.chunk_word[14:13], ok);
                    end
                    close_run();
                    if (!ok)
                    begin
                        emit_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, tcd_pkg::ERR_CAPACITY);
                        msg_done = 1'b1;
                    end
                    else if (status_idx >= msg_total)
                    begin
                        emit_row(tcd_pkg::KIND_SUMMARY, '0, '0, '0, tcd_pkg::ERR_NONE);
                        msg_done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (row_held)
        begin
            entry.row  = held_row;
            entry.last = 1'b1;
            expected_results.push_back(entry);
        end
    endtask

    // ---------------------------------------------------------------------
    // Input driver: offers pending transactions, holds payload while stalled
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_status_decode({opcode, base_sequence, status_count, chunk_word});
                accepted_txns <= accepted_txns + 1;
            end
            // only move on once the current transaction is gone
            if (!in_valid || !in_stall)
            begin
                if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid      <= 1'b1;
                    opcode        <= pending_txns[0].opcode;
                    base_sequence <= pending_txns[0].base_sequence;
                    status_count  <= pending_txns[0].status_count;
                    chunk_word    <= pending_txns[0].chunk_word;
                    void'(pending_txns.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output stall: random mix, plus one long hold-off so the block backs
    // up and stalls its input while the driver keeps offering
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_txns >= HOLD_AFTER)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Result monitor: each accepted result against the oldest expectation
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        expected_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no transaction pending: kind %0d err %0d",
                       result_kind, error_code);
                mismatch_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                check_field("result_kind", exp_res.row.kind, result_kind);
                check_field("run_first_sequence", exp_res.row.first_seq, run_first_sequence);
                check_field("run_length", exp_res.row.length, run_length);
                check_field("run_status", exp_res.row.status, run_status);
                check_field("received_total", exp_res.row.recv_total, received_total);
                check_field("status_bytes", exp_res.row.st_bytes, status_bytes);
                check_field("timing_bytes", exp_res.row.tm_bytes, timing_bytes);
                check_field("error_code", exp_res.row.err, error_code);
                check_field("last", exp_res.last, last);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_txn(input logic [1:0] op, input logic [15:0] base,
                            input logic [15:0] count, input logic [15:0] word);
        decoder_txn_t txn;
        txn.opcode        = op;
        txn.base_sequence = base;
        txn.status_count  = count;
        txn.chunk_word    = word;
        pending_txns.push_back(txn);
    endtask

    // Mostly well-formed messages: begin, a few chunks, sometimes an end.
    // About one draw in eight queues a single transaction of pure noise.
    task automatic queue_random_messages(input int target);
        int          queued;
        int          n_chunks;
        int          k;
        logic [15:0] cnt;
        logic [15:0] w;
        queued = 0;
        while (queued < target)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_txn(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         16'($urandom));
                queued++;
            end
            else
            begin
                // large counts keep the message open until an end or a new begin
                cnt = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 40));
                push_txn(tcd_pkg::OP_BEGIN, 16'($urandom), cnt, 16'($urandom));
                queued++;
                n_chunks = $urandom_range(1, 6);
                for (k = 0; k < n_chunks; k++)
                begin
                    if ($urandom_range(99) < 50)
                        w = {1'b1, 15'($urandom)};
                    else if ($urandom_range(99) < 15)
                        w = {1'b0, 15'($urandom)};
                    else
                        w = {1'b0, 2'($urandom_range(0, 3)), 13'($urandom_range(0, 12))};
                    push_txn(tcd_pkg::OP_CHUNK, 16'($urandom), 16'($urandom), w);
                    queued++;
                end
                if ($urandom_range(99) < 35)
                begin
                    push_txn(tcd_pkg::OP_END, 16'($urandom), 16'($urandom), 16'($urandom));
                    queued++;
                end
            end
        end
    endtask

    // all sent, all results in, then settle so a dropped transaction
    // still in flight finishes before anything else happens
    task automatic wait_drained();
        while (pending_txns.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en        <= 1'b1;
        cfg_wr_data      <= value;
        capacity_setting = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Segment 0: reset capacity, receiver busy, sender mostly ready
        send_idle_pct = 9;
        recv_idle_pct = 51;
        // no message open yet: chunk, end and the unused opcode are dropped
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hFFFF);
        push_txn(tcd_pkg::OP_END, 16'h0000, 16'h0000, 16'h0000);
        push_txn(OP_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // empty message closes at once
        push_txn(tcd_pkg::OP_BEGIN, 16'hFFF0, 16'h0000, 16'h0000);
        // two-bit vector across the sequence wrap, then a one-bit vector
        // that reaches the count partway through
        push_txn(tcd_pkg::OP_BEGIN, 16'hFFFE, 16'd20, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hDB3D);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hBFF0);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h0000);
        // longest run, zero-length run, then out of data
        push_txn(tcd_pkg::OP_BEGIN, 16'd100, 16'd8192, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h3FFF);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h2000);
        push_txn(tcd_pkg::OP_END, 16'h0000, 16'h0000, 16'h0000);
        // begin over an open message
        push_txn(tcd_pkg::OP_BEGIN, 16'd7, 16'd50, 16'h0000);
        push_txn(tcd_pkg::OP_BEGIN, 16'd9, 16'd2, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h4005);
        // zero statuses only: summary with no runs
        push_txn(tcd_pkg::OP_BEGIN, 16'h1234, 16'd10, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h0003);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h8000);
        // reserved status, alternating one-bit vector, largest count
        push_txn(tcd_pkg::OP_BEGIN, 16'h0000, 16'hFFFF, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hFFFF);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h6004);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hAAAA);
        push_txn(tcd_pkg::OP_END, 16'h0000, 16'h0000, 16'h0000);
        queue_random_messages(70);
        wait_drained();

        // Segment 1: zero capacity, sender gappy, receiver mostly ready
        send_idle_pct = 51;
        recv_idle_pct = 9;
        write_capacity(16'd0);
        push_txn(tcd_pkg::OP_BEGIN, 16'd5, 16'd5, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h2005);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h2005);
        push_txn(tcd_pkg::OP_BEGIN, 16'd0, 16'd3, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'h0003);
        queue_random_messages(15);
        wait_drained();

        // Segment 2: capacity runs out partway through a vector
        write_capacity(16'd3);
        push_txn(tcd_pkg::OP_BEGIN, 16'hFFFF, 16'd10, 16'h0000);
        push_txn(tcd_pkg::OP_CHUNK, 16'h0000, 16'h0000, 16'hD5FF);
        wait_drained();
        write_capacity(16'($urandom_range(1, 30)));
        queue_random_messages(50);
        wait_drained();

        // Segment 3: full capacity, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(tcd_pkg::CAPACITY_RESET);
        queue_random_messages(60);
        wait_drained();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
